// ===== sv/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL; they compile to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: property violated");
// Checks that a condition is never true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== sv/tsrq_pkg.sv =====
// Shared types and constants of the thread slot and ready queue scheduler.
package tsrq_pkg;

   localparam int MODE_W   = 2;
   localparam int TARGET_W = 8;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int TID_W    = 7;

   typedef enum logic [MODE_W-1:0] {
      MODE_CREATE   = 2'd0,
      MODE_YIELD    = 2'd1,
      MODE_SCHEDULE = 2'd2,
      MODE_EXIT     = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 3'd0,
      STAT_NO_SLOT = 3'd1,
      STAT_BAD_ID  = 3'd2,
      STAT_ABSENT  = 3'd3,
      STAT_HALTED  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEARCH,
      ST_PASS,
      ST_FINISH,
      ST_READ,
      ST_RESPOND
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       ready;
      logic       load;
      logic       search_init;
      logic       search_step;
      logic       create_commit;
      logic       pass_init;
      logic       pass_run;
      logic       finish;
      logic       read_run;
      logic       respond;
      logic       set_status;
      status_type code;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic     req_valid;
      logic     out_free;
      logic     halted;
      mode_type mode;
      logic     target_bad;
      logic     target_absent;
      logic     queue_empty;
      logic     slot_free;
      logic     search_last;
      logic     pass_done;
   } sts_type;

endpackage

// ===== sv/tsrq_req_if.sv =====
// Request channel of the scheduler: valid, ready and one request beat.
interface tsrq_req_if;
   logic                              valid;
   logic                              ready;
   logic [tsrq_pkg::MODE_W-1:0]       mode;
   logic [tsrq_pkg::TARGET_W-1:0]     target;
   logic [tsrq_pkg::DATA_W-1:0]       entry_address;
   logic signed [tsrq_pkg::DATA_W-1:0] argument;

   modport source (output valid, output mode, output target, output entry_address,
                   output argument, input ready);
   modport sink (input valid, input mode, input target, input entry_address,
                 input argument, output ready);
endinterface

// ===== sv/tsrq_rsp_if.sv =====
// Response channel of the scheduler: valid, ready and one response beat.
interface tsrq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [tsrq_pkg::STATUS_W-1:0]      status;
   logic signed [tsrq_pkg::TID_W-1:0]  result_id;
   logic signed [tsrq_pkg::TID_W-1:0]  current_thread;
   logic                               switched;
   logic [tsrq_pkg::DATA_W-1:0]        run_entry;
   logic signed [tsrq_pkg::DATA_W-1:0] run_argument;
   logic                               halted;

   modport source (output valid, output status, output result_id, output current_thread,
                   output switched, output run_entry, output run_argument, output halted,
                   input ready);
   modport sink (input valid, input status, input result_id, input current_thread,
                 input switched, input run_entry, input run_argument, input halted,
                 output ready);
endinterface

// ===== sv/thread_slot_and_ready_queue_scheduler.sv =====
// Top level of the thread slot and ready queue scheduler.
//
// The block keeps a table of MAX_THREADS thread slots and a first-in first-out ready
// queue of thread ids, and answers every request beat (create, yield, schedule, exit)
// with exactly one response beat. Slot 0 is the running main thread after reset; its
// entry and argument read back as unknown until a create reuses that slot. A request
// is taken only while the block is idle, and one request is worked on at a time. A
// create walks the slots round-robin, one slot per cycle, until it finds a free
// slot or has tried every slot. Yield, schedule and exit make one compaction pass
// over the ready queue memory, one entry per cycle through its single read port; a
// yield with a bad or absent target, a schedule with an empty queue and any request
// while halted skip the pass. Once the last thread exits with an empty queue the
// block halts and answers every later request with status halted until reset. The
// response register frees the input side: the next request is accepted while a
// finished response still waits to be taken, and only the final load of a response
// waits for the register to empty.
module thread_slot_and_ready_queue_scheduler #(
   parameter int MAX_THREADS = 16
) (
   input logic        clock,
   input logic        reset,
   tsrq_req_if.sink   req_bus,
   tsrq_rsp_if.source rsp_bus
);

   // Command and status groups between the state machine and the datapath.
   tsrq_pkg::cmd_type cmd;
   tsrq_pkg::sts_type sts;

   // The controller sequences each request: decode, slot search or queue pass,
   // commit, slot data read and response load.
   tsrq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // The datapath holds the slot table, the queue memory, the running thread and
   // the response register, and drives both channels.
   tsrq_datapath #(
      .MAX_THREADS (MAX_THREADS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cmd     (cmd),
      .sts     (sts)
   );

endmodule

// ===== sv/tsrq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module tsrq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tsrq_ctrl.sv =====
// Controller state machine of the scheduler: sequences decode, slot search and queue pass.
`include "assert_macros.svh"

module tsrq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  tsrq_pkg::sts_type sts,
   output tsrq_pkg::cmd_type cmd
);

   tsrq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsrq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsrq_pkg::ST_IDLE: begin
            if (sts.req_valid) begin
               state_in = tsrq_pkg::ST_DECODE;
            end
         end
         tsrq_pkg::ST_DECODE: begin
            if (sts.halted) begin
               state_in = tsrq_pkg::ST_READ;
            end else begin
               unique case (sts.mode)
                  tsrq_pkg::MODE_CREATE: state_in = tsrq_pkg::ST_SEARCH;
                  tsrq_pkg::MODE_YIELD: begin
                     if (sts.target_bad || sts.target_absent) begin
                        state_in = tsrq_pkg::ST_READ;
                     end else begin
                        state_in = tsrq_pkg::ST_PASS;
                     end
                  end
                  tsrq_pkg::MODE_SCHEDULE: begin
                     if (sts.queue_empty) begin
                        state_in = tsrq_pkg::ST_READ;
                     end else begin
                        state_in = tsrq_pkg::ST_PASS;
                     end
                  end
                  tsrq_pkg::MODE_EXIT: state_in = tsrq_pkg::ST_PASS;
               endcase
            end
         end
         tsrq_pkg::ST_SEARCH: begin
            if (sts.slot_free || sts.search_last) begin
               state_in = tsrq_pkg::ST_READ;
            end
         end
         tsrq_pkg::ST_PASS: begin
            if (sts.pass_done) begin
               state_in = tsrq_pkg::ST_FINISH;
            end
         end
         tsrq_pkg::ST_FINISH: state_in = tsrq_pkg::ST_READ;
         tsrq_pkg::ST_READ: state_in = tsrq_pkg::ST_RESPOND;
         tsrq_pkg::ST_RESPOND: begin
            if (sts.out_free) begin
               state_in = tsrq_pkg::ST_IDLE;
            end
         end
         default: state_in = tsrq_pkg::ST_IDLE;
      endcase
   end

   // Commands.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         tsrq_pkg::ST_IDLE: begin
            cmd.ready = 1'b1;
            cmd.load  = sts.req_valid;
         end
         tsrq_pkg::ST_DECODE: begin
            if (sts.halted) begin
               cmd.set_status = 1'b1;
               cmd.code       = tsrq_pkg::STAT_HALTED;
            end else begin
               unique case (sts.mode)
                  tsrq_pkg::MODE_CREATE: cmd.search_init = 1'b1;
                  tsrq_pkg::MODE_YIELD: begin
                     priority if (sts.target_bad) begin
                        cmd.set_status = 1'b1;
                        cmd.code       = tsrq_pkg::STAT_BAD_ID;
                     end else if (sts.target_absent) begin
                        cmd.set_status = 1'b1;
                        cmd.code       = tsrq_pkg::STAT_ABSENT;
                     end else begin
                        cmd.pass_init = 1'b1;
                     end
                  end
                  tsrq_pkg::MODE_SCHEDULE: cmd.pass_init = !sts.queue_empty;
                  tsrq_pkg::MODE_EXIT: cmd.pass_init = 1'b1;
               endcase
            end
         end
         tsrq_pkg::ST_SEARCH: begin
            priority if (sts.slot_free) begin
               cmd.create_commit = 1'b1;
            end else if (sts.search_last) begin
               cmd.set_status = 1'b1;
               cmd.code       = tsrq_pkg::STAT_NO_SLOT;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         tsrq_pkg::ST_PASS: cmd.pass_run = 1'b1;
         tsrq_pkg::ST_FINISH: cmd.finish = 1'b1;
         tsrq_pkg::ST_READ: cmd.read_run = 1'b1;
         tsrq_pkg::ST_RESPOND: cmd.respond = sts.out_free;
         default: cmd = '0;
      endcase
   end

   `ASSERT_PROP(a_load_goes_decode, clock, reset, cmd.load |=> state_ff == tsrq_pkg::ST_DECODE)
   `ASSERT_PROP(a_pass_exits_to_finish, clock, reset, state_ff == tsrq_pkg::ST_PASS |=> state_ff == tsrq_pkg::ST_PASS || state_ff == tsrq_pkg::ST_FINISH)
   `ASSERT_PROP(a_one_action, clock, reset, $onehot0({cmd.load, cmd.search_step, cmd.create_commit, cmd.pass_run, cmd.finish, cmd.read_run, cmd.respond}))

endmodule

// ===== sv/tsrq_datapath.sv =====
// Datapath of the scheduler: slot table, ready queue memory, counters and response register.
`include "assert_macros.svh"

module tsrq_datapath #(
   parameter int MAX_THREADS = 16
) (
   input  logic              clock,
   input  logic              reset,
   tsrq_req_if.sink          req_bus,
   tsrq_rsp_if.source        rsp_bus,
   input  tsrq_pkg::cmd_type cmd,
   output tsrq_pkg::sts_type sts
);

   localparam int IW     = $clog2(MAX_THREADS);
   localparam int CW     = $clog2(MAX_THREADS + 1);
   localparam int PAD    = tsrq_pkg::TID_W - IW;
   localparam int DW     = tsrq_pkg::DATA_W;
   localparam int SLOT_W = 2 * DW;

   // Control state.
   logic [MAX_THREADS-1:0] valid_ff, valid_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [IW-1:0]          run_ff, run_in;
   logic                   halted_ff, halted_in;
   logic [IW-1:0]          search_ff, search_in;
   logic [CW-1:0]          rd_ff, rd_in;
   logic [CW-1:0]          wr_ff, wr_in;
   logic                   pend_ff, pend_in;
   logic                   found_ff, found_in;
   logic                   out_valid_ff, out_valid_in;

   // Working and payload registers.
   tsrq_pkg::mode_type          mode_ff, mode_in;
   logic [tsrq_pkg::TARGET_W-1:0] target_ff, target_in;
   logic [DW-1:0]               entry_ff, entry_in;
   logic [DW-1:0]               arg_ff, arg_in;
   logic [IW-1:0]               cand_ff, cand_in;
   logic [IW-1:0]               steps_ff, steps_in;
   logic                        first_ff, first_in;
   logic [IW-1:0]               head_ff, head_in;
   tsrq_pkg::status_type        stat_ff, stat_in;
   logic [tsrq_pkg::TID_W-1:0]  result_ff, result_in;
   logic                        switch_ff, switch_in;
   tsrq_pkg::status_type        out_status_ff, out_status_in;
   logic [tsrq_pkg::TID_W-1:0]  out_result_ff, out_result_in;
   logic [tsrq_pkg::TID_W-1:0]  out_current_ff, out_current_in;
   logic                        out_switch_ff, out_switch_in;
   logic [DW-1:0]               out_entry_ff, out_entry_in;
   logic [DW-1:0]               out_arg_ff, out_arg_in;
   logic                        out_halted_ff, out_halted_in;

   // Memory ports.
   logic [SLOT_W-1:0] slot_rd;
   logic              q_we;
   logic              q_re;
   logic [IW-1:0]     q_waddr;
   logic [IW-1:0]     q_wdata;
   logic [IW-1:0]     q_rd;

   // Derived conditions.
   logic [IW-1:0] tgt_id;
   logic          target_bad;
   logic          rd_more;
   logic          is_run;
   logic          capture;
   logic          keep;
   logic          wr_room;
   logic          count_room;
   logic          append_fin;

   assign tgt_id     = target_ff[IW-1:0];
   assign target_bad = target_ff >= tsrq_pkg::TARGET_W'(MAX_THREADS);
   assign rd_more    = rd_ff != count_ff;
   assign is_run     = q_rd == run_ff;
   // Schedule takes the entry at the queue head; exit takes the first entry that
   // is not the exiting thread.
   assign capture    = (mode_ff == tsrq_pkg::MODE_SCHEDULE && first_ff) ||
                       (mode_ff == tsrq_pkg::MODE_EXIT && !is_run && !found_ff);
   assign keep       = pend_ff && !(is_run || capture ||
                       (mode_ff == tsrq_pkg::MODE_YIELD && q_rd == tgt_id));
   assign wr_room    = wr_ff != CW'(MAX_THREADS);
   assign count_room = count_ff != CW'(MAX_THREADS);
   assign append_fin = cmd.finish && wr_room &&
                       (mode_ff == tsrq_pkg::MODE_YIELD || mode_ff == tsrq_pkg::MODE_SCHEDULE);

   assign q_we    = (cmd.pass_run && keep) || (cmd.create_commit && count_room) || append_fin;
   assign q_re    = cmd.pass_run && rd_more;
   assign q_waddr = cmd.create_commit ? count_ff[IW-1:0] : wr_ff[IW-1:0];
   assign q_wdata = cmd.create_commit ? cand_ff : (cmd.pass_run ? q_rd : run_ff);

   tsrq_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (MAX_THREADS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.create_commit),
      .wr_addr (cand_ff),
      .wr_data ({entry_ff, arg_ff}),
      .rd_en   (cmd.read_run),
      .rd_addr (run_ff),
      .rd_data (slot_rd)
   );

   tsrq_ram #(
      .WIDTH (IW),
      .DEPTH (MAX_THREADS)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_en   (q_re),
      .rd_addr (rd_ff[IW-1:0]),
      .rd_data (q_rd)
   );

   always_comb begin
      valid_in       = valid_ff;
      count_in       = count_ff;
      run_in         = run_ff;
      halted_in      = halted_ff;
      search_in      = search_ff;
      rd_in          = rd_ff;
      wr_in          = wr_ff;
      pend_in        = pend_ff;
      found_in       = found_ff;
      mode_in        = mode_ff;
      target_in      = target_ff;
      entry_in       = entry_ff;
      arg_in         = arg_ff;
      cand_in        = cand_ff;
      steps_in       = steps_ff;
      first_in       = first_ff;
      head_in        = head_ff;
      stat_in        = stat_ff;
      result_in      = result_ff;
      switch_in      = switch_ff;
      out_valid_in   = out_valid_ff;
      out_status_in  = out_status_ff;
      out_result_in  = out_result_ff;
      out_current_in = out_current_ff;
      out_switch_in  = out_switch_ff;
      out_entry_in   = out_entry_ff;
      out_arg_in     = out_arg_ff;
      out_halted_in  = out_halted_ff;

      if (cmd.load) begin
         mode_in   = tsrq_pkg::mode_type'(req_bus.mode);
         target_in = req_bus.target;
         entry_in  = req_bus.entry_address;
         arg_in    = req_bus.argument;
         stat_in   = tsrq_pkg::STAT_OK;
         result_in = '1;
         switch_in = 1'b0;
      end
      if (cmd.set_status) begin
         stat_in = cmd.code;
      end
      if (cmd.search_init) begin
         cand_in  = search_ff;
         steps_in = '0;
      end
      if (cmd.search_step) begin
         cand_in  = (cand_ff == IW'(MAX_THREADS - 1)) ? '0 : cand_ff + IW'(1);
         steps_in = steps_ff + IW'(1);
      end
      if (cmd.create_commit) begin
         valid_in[cand_ff] = 1'b1;
         search_in         = cand_ff;
         result_in         = {{PAD{1'b0}}, cand_ff};
         if (count_room) begin
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.pass_init) begin
         rd_in    = '0;
         wr_in    = '0;
         pend_in  = 1'b0;
         found_in = 1'b0;
      end
      if (cmd.pass_run) begin
         pend_in  = rd_more;
         first_in = rd_ff == '0;
         if (rd_more) begin
            rd_in = rd_ff + CW'(1);
         end
         if (pend_ff && capture) begin
            head_in  = q_rd;
            found_in = 1'b1;
         end
         if (keep) begin
            wr_in = wr_ff + CW'(1);
         end
      end
      if (cmd.finish) begin
         unique case (mode_ff)
            tsrq_pkg::MODE_YIELD: begin
               run_in    = tgt_id;
               result_in = {{PAD{1'b0}}, run_ff};
               switch_in = tgt_id != run_ff;
               count_in  = wr_ff + CW'(wr_room);
            end
            tsrq_pkg::MODE_SCHEDULE: begin
               run_in    = head_ff;
               result_in = {{PAD{1'b0}}, run_ff};
               switch_in = head_ff != run_ff;
               count_in  = wr_ff + CW'(wr_room);
            end
            tsrq_pkg::MODE_EXIT: begin
               valid_in[run_ff] = 1'b0;
               count_in         = wr_ff;
               if (found_ff) begin
                  run_in    = head_ff;
                  switch_in = 1'b1;
               end else begin
                  halted_in = 1'b1;
                  stat_in   = tsrq_pkg::STAT_HALTED;
               end
            end
            tsrq_pkg::MODE_CREATE: begin
               run_in = run_ff;
            end
         endcase
      end
      if (cmd.respond) begin
         out_valid_in   = 1'b1;
         out_status_in  = stat_ff;
         out_result_in  = result_ff;
         out_switch_in  = switch_ff;
         out_halted_in  = halted_ff;
         out_current_in = halted_ff ? '1 : {{PAD{1'b0}}, run_ff};
         out_entry_in   = halted_ff ? '0 : slot_rd[SLOT_W-1:DW];
         out_arg_in     = halted_ff ? '0 : slot_rd[DW-1:0];
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= MAX_THREADS'(1);
         count_ff     <= '0;
         run_ff       <= '0;
         halted_ff    <= 1'b0;
         search_ff    <= '0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         run_ff       <= run_in;
         halted_ff    <= halted_in;
         search_ff    <= search_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      target_ff      <= target_in;
      entry_ff       <= entry_in;
      arg_ff         <= arg_in;
      cand_ff        <= cand_in;
      steps_ff       <= steps_in;
      first_ff       <= first_in;
      head_ff        <= head_in;
      stat_ff        <= stat_in;
      result_ff      <= result_in;
      switch_ff      <= switch_in;
      out_status_ff  <= out_status_in;
      out_result_ff  <= out_result_in;
      out_current_ff <= out_current_in;
      out_switch_ff  <= out_switch_in;
      out_entry_ff   <= out_entry_in;
      out_arg_ff     <= out_arg_in;
      out_halted_ff  <= out_halted_in;
   end

   assign req_bus.ready = cmd.ready;

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.status         = out_status_ff;
   assign rsp_bus.result_id      = out_result_ff;
   assign rsp_bus.current_thread = out_current_ff;
   assign rsp_bus.switched       = out_switch_ff;
   assign rsp_bus.run_entry      = out_entry_ff;
   assign rsp_bus.run_argument   = out_arg_ff;
   assign rsp_bus.halted         = out_halted_ff;

   always_comb begin
      sts               = '0;
      sts.req_valid     = req_bus.valid;
      sts.out_free      = !out_valid_ff || rsp_bus.ready;
      sts.halted        = halted_ff;
      sts.mode          = mode_ff;
      sts.target_bad    = target_bad;
      sts.target_absent = !valid_ff[tgt_id];
      sts.queue_empty   = count_ff == '0;
      sts.slot_free     = !valid_ff[cand_ff];
      sts.search_last   = steps_ff == IW'(MAX_THREADS - 1);
      sts.pass_done     = !rd_more && !pend_ff;
   end

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CW'(MAX_THREADS))
   `ASSERT_PROP(a_running_slot_valid, clock, reset, !halted_ff |-> valid_ff[run_ff])
   `ASSERT_PROP(a_halt_sticky, clock, reset, halted_ff |=> halted_ff)
   `ASSERT_PROP(a_write_behind_read, clock, reset, cmd.pass_run |-> wr_ff <= rd_ff)

endmodule

// ===== tb/thread_slot_and_ready_queue_scheduler_checker.sv =====
// Monitors both scheduler channels, predicts every reply and compares it with the block.
module thread_slot_and_ready_queue_scheduler_checker #(
   parameter int THREADS = 16
) (
   input  logic  clock,
   input  logic  reset,
   tsrq_req_if   req_bus,
   tsrq_rsp_if   rsp_bus,
   output int    failures,
   output int    outstanding
);
   import tsrq_pkg::*;

   localparam logic signed [TID_W-1:0] NO_THREAD = -1;

   typedef struct {
      status_type               status;
      logic signed [TID_W-1:0]  result_id;
      logic signed [TID_W-1:0]  current;
      logic                     switched;
      logic [DATA_W-1:0]        run_entry;
      logic [DATA_W-1:0]        run_argument;
      logic                     halted;
      bit                       data_known;
   } reply_type;

   // Shadow of the scheduler state.
   bit                slot_live[THREADS];
   bit                slot_loaded[THREADS];
   logic [DATA_W-1:0] slot_pc[THREADS];
   logic [DATA_W-1:0] slot_arg[THREADS];
   int unsigned       ready_queue[$];
   int unsigned       running;
   bit                nobody_running;
   int unsigned       search_from;
   bit                stopped;

   reply_type pending_replies[$];
   int        mismatch_count = 0;

   assign failures = mismatch_count;

   function automatic void clear_shadow();
      for (int i = 0; i < THREADS; i++) begin
         slot_live[i]   = (i == 0);
         slot_loaded[i] = 1'b0;
         slot_pc[i]     = '0;
         slot_arg[i]    = '0;
      end
      ready_queue.delete();
      running        = 0;
      nobody_running = 1'b0;
      search_from    = 0;
      stopped        = 1'b0;
   endfunction

   function automatic void unqueue(int unsigned tid);
      int idx;
      idx = -1;
      for (int i = 0; i < ready_queue.size(); i++) begin
         if (ready_queue[i] == tid) begin
            idx = i;
            break;
         end
      end
      if (idx >= 0) ready_queue.delete(idx);
   endfunction

   function automatic void enqueue(int unsigned tid);
      if (ready_queue.size() < THREADS) ready_queue.push_back(tid);
   endfunction

   function automatic reply_type predict_reply(mode_type mode, logic [TARGET_W-1:0] target,
                                               logic [DATA_W-1:0] pc, logic [DATA_W-1:0] arg);
      reply_type   r;
      int unsigned slot;
      int unsigned prev;
      int unsigned head;
      bit          found;
      r.status    = STAT_OK;
      r.result_id = NO_THREAD;
      r.switched  = 1'b0;
      if (stopped) begin
         r.status = STAT_HALTED;
      end else begin
         case (mode)
            MODE_CREATE: begin
               found = 1'b0;
               for (int i = 0; i < THREADS; i++) begin
                  slot = (search_from + i) % THREADS;
                  if (!slot_live[slot]) begin
                     search_from       = slot;
                     slot_live[slot]   = 1'b1;
                     slot_loaded[slot] = 1'b1;
                     slot_pc[slot]     = pc;
                     slot_arg[slot]    = arg;
                     enqueue(slot);
                     r.result_id = TID_W'(slot);
                     found = 1'b1;
                     break;
                  end
               end
               if (!found) r.status = STAT_NO_SLOT;
            end
            MODE_YIELD: begin
               if (target >= THREADS) begin
                  r.status = STAT_BAD_ID;
               end else if (!slot_live[target]) begin
                  r.status = STAT_ABSENT;
               end else begin
                  prev    = running;
                  running = target;
                  unqueue(prev);
                  unqueue(target);
                  enqueue(prev);
                  r.result_id = TID_W'(prev);
                  r.switched  = (target != prev);
               end
            end
            MODE_SCHEDULE: begin
               if (ready_queue.size() > 0) begin
                  prev    = running;
                  head    = ready_queue.pop_front();
                  running = head;
                  unqueue(prev);
                  enqueue(prev);
                  r.result_id = TID_W'(prev);
                  r.switched  = (head != prev);
               end
            end
            MODE_EXIT: begin
               slot_live[running % THREADS] = 1'b0;
               unqueue(running);
               if (ready_queue.size() > 0) begin
                  running    = ready_queue.pop_front();
                  r.switched = 1'b1;
               end else begin
                  nobody_running = 1'b1;
                  stopped        = 1'b1;
                  r.status       = STAT_HALTED;
               end
            end
            default: ;
         endcase
      end
      if (nobody_running) begin
         r.current      = NO_THREAD;
         r.run_entry    = '0;
         r.run_argument = '0;
         r.data_known   = 1'b1;
      end else begin
         r.current      = TID_W'(running);
         r.run_entry    = slot_pc[running % THREADS];
         r.run_argument = slot_arg[running % THREADS];
         // The main thread's data is undefined until a create fills its slot.
         r.data_known   = slot_loaded[running % THREADS];
      end
      r.halted = stopped;
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      bit        took;
      bit        gave;
      bit        bad;
      if (reset) begin
         clear_shadow();
         pending_replies.delete();
         outstanding <= 0;
      end else begin
         took = req_bus.valid && req_bus.ready;
         gave = rsp_bus.valid && rsp_bus.ready;
         if (gave) begin
            if (pending_replies.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: reply beat with no request pending: status %0d id %0d",
                           $time, rsp_bus.status, rsp_bus.result_id);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = pending_replies.pop_front();
               bad = (rsp_bus.status !== want.status) ||
                     (rsp_bus.result_id !== want.result_id) ||
                     (rsp_bus.current_thread !== want.current) ||
                     (rsp_bus.switched !== want.switched) ||
                     (rsp_bus.halted !== want.halted) ||
                     (want.data_known && ((rsp_bus.run_entry !== want.run_entry) ||
                                          (rsp_bus.run_argument !== want.run_argument)));
               if (bad) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: reply mismatch, expected st %0d id %0d cur %0d sw %0d %s",
                              $time, want.status, want.result_id, want.current,
                              want.switched, "(entry, argument, halted below)");
                     $display("   expected entry %h arg %h halt %0d (data known %0d)",
                              want.run_entry, want.run_argument, want.halted,
                              want.data_known);
                     $display("   got st %0d id %0d cur %0d sw %0d entry %h arg %h halt %0d",
                              rsp_bus.status, rsp_bus.result_id, rsp_bus.current_thread,
                              rsp_bus.switched, rsp_bus.run_entry, rsp_bus.run_argument,
                              rsp_bus.halted);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (took)
            pending_replies.push_back(predict_reply(mode_type'(req_bus.mode), req_bus.target,
                                                    req_bus.entry_address, req_bus.argument));
         outstanding <= outstanding + int'(took) - int'(gave);
      end
   end

endmodule

// ===== tb/thread_slot_and_ready_queue_scheduler_tb.sv =====
// Testbench top: clock, reset, request stimulus, reply stalls and the final verdict.
module thread_slot_and_ready_queue_scheduler_tb;
   import tsrq_pkg::*;

   localparam int THREADS       = 16;
   localparam int RANDOM_ITEMS  = 380;
   localparam int SETTLE_CYCLES = 40;
   // Far beyond the slowest legal run: about 400 beats, each with its block work,
   // sender gaps and receiver stalls.
   localparam int RUN_LIMIT     = 2000000;

   logic clock;
   logic reset;

   tsrq_req_if req_bus ();
   tsrq_rsp_if rsp_bus ();

   int failures;
   int outstanding;

   // Number of valid thread slots as seen by the stimulus. Every valid thread
   // other than the running one sits in the ready queue once an exit has
   // removed the running thread, so an exit halts the block exactly when this
   // count is one. The stimulus uses it to keep the halt for the very end.
   int live_threads = 1;
   bit halt_sent    = 1'b0;
   int burst_left   = 0;

   // Receiver stall pattern state.
   int stall_style = 0;
   int style_left  = 0;

   thread_slot_and_ready_queue_scheduler #(
      .MAX_THREADS (THREADS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   thread_slot_and_ready_queue_scheduler_checker #(
      .THREADS (THREADS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always #2 clock = ~clock;

   // The receiver switches at random between a few stall styles:
   // always ready, a coin flip, mostly stalled, and long blocked stretches that
   // open for one cycle in sixteen.
   always @(posedge clock) begin
      if (style_left == 0) begin
         stall_style <= $urandom_range(0, 3);
         style_left  <= $urandom_range(20, 150);
      end else begin
         style_left <= style_left - 1;
      end
      case (stall_style)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= 1'($urandom_range(0, 1));
         2: rsp_bus.ready <= ($urandom_range(0, 5) == 0);
         default: rsp_bus.ready <= (style_left % 16 == 0);
      endcase
   end

   // Presents one request beat and returns at the edge that accepts it. The
   // sender works in bursts of random length; a burst may start after a gap.
   task automatic send_request(mode_type mode, logic [TARGET_W-1:0] target,
                               logic [DATA_W-1:0] pc, logic [DATA_W-1:0] arg);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      if (!halt_sent) begin
         case (mode)
            MODE_CREATE: if (live_threads < THREADS) live_threads++;
            MODE_EXIT: begin
               if (live_threads == 1) halt_sent = 1'b1;
               live_threads--;
            end
            default: ;
         endcase
      end
      req_bus.mode          <= mode;
      req_bus.target        <= target;
      req_bus.entry_address <= pc;
      req_bus.argument      <= arg;
      req_bus.valid         <= 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // Holds the sender off until every reply beat has been taken.
   task automatic drain_replies();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // One random request. Growing phases favor create, shrinking phases favor
   // exit, so the slot table sweeps between nearly empty and full. An exit of
   // the last thread would halt the block for good, so it becomes a schedule.
   task automatic send_random(bit growing);
      int                  pick;
      logic [TARGET_W-1:0] tgt;
      pick = $urandom_range(0, 99);
      tgt  = ($urandom_range(0, 4) == 0) ? TARGET_W'($urandom_range(THREADS, 255))
                                         : TARGET_W'($urandom_range(0, THREADS - 1));
      if (pick < (growing ? 40 : 12))
         send_request(MODE_CREATE, tgt, $urandom(), $urandom());
      else if (pick < (growing ? 70 : 45))
         send_request(MODE_YIELD, tgt, $urandom(), $urandom());
      else if (pick < (growing ? 90 : 65) || live_threads <= 1)
         send_request(MODE_SCHEDULE, tgt, $urandom(), $urandom());
      else
         send_request(MODE_EXIT, tgt, $urandom(), $urandom());
   endtask

   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.mode          = MODE_CREATE;
      req_bus.target        = '0;
      req_bus.entry_address = '0;
      req_bus.argument      = '0;
      rsp_bus.ready         = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed opening. Right after reset only the main thread runs and the
      // ready queue is empty, so the first schedule has nothing to switch to.
      send_request(MODE_SCHEDULE, 8'd0, 32'h0, 32'h0);
      // Yield to the running thread puts it on the queue without a switch,
      // and the following schedule finds itself at the head.
      send_request(MODE_YIELD, 8'd0, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_request(MODE_SCHEDULE, 8'd0, 32'h0, 32'h0);
      // Ids out of range, then an id in range whose slot is free.
      send_request(MODE_YIELD, 8'd255, 32'h0, 32'h0);
      send_request(MODE_YIELD, 8'd16, 32'h0, 32'h0);
      send_request(MODE_YIELD, 8'd15, 32'h0, 32'h0);
      // Creates carrying the extreme entries and arguments.
      send_request(MODE_CREATE, 8'd0, 32'h00000000, 32'h80000000);
      send_request(MODE_CREATE, 8'd0, 32'hFFFFFFFF, 32'h7FFFFFFF);
      send_request(MODE_CREATE, 8'd0, 32'h55555555, 32'hFFFFFFFF);
      send_request(MODE_CREATE, 8'd0, 32'hAAAAAAAA, 32'h00000000);
      // Real switches, then an exit that hands over to the queue head.
      send_request(MODE_YIELD, 8'd2, 32'h0, 32'h0);
      send_request(MODE_SCHEDULE, 8'd0, 32'h0, 32'h0);
      send_request(MODE_SCHEDULE, 8'd0, 32'h0, 32'h0);
      send_request(MODE_EXIT, 8'd0, 32'h0, 32'h0);
      send_request(MODE_CREATE, 8'd0, 32'h12345678, 32'h87654321);
      send_request(MODE_YIELD, 8'd128, 32'h0, 32'h0);
      send_request(MODE_YIELD, 8'd64, 32'h0, 32'h0);
      send_request(MODE_YIELD, 8'd3, 32'h0, 32'h0);
      send_request(MODE_EXIT, 8'd0, 32'h0, 32'h0);

      // Random part, in alternating growing and shrinking phases of 50 beats.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150) begin
            // Fill every slot, then ask for two more to hit the full table.
            while (live_threads < THREADS)
               send_request(MODE_CREATE, 8'($urandom()), $urandom(), $urandom());
            repeat (2) send_request(MODE_CREATE, 8'($urandom()), $urandom(), $urandom());
         end
         if (n == 260) drain_replies();
         send_random((n / 50) % 2 == 0);
      end

      // Retire every thread; the last exit halts the block, and the beats after
      // it must all come back halted.
      while (live_threads > 1)
         send_request(MODE_EXIT, 8'($urandom()), $urandom(), $urandom());
      send_request(MODE_EXIT, 8'($urandom()), $urandom(), $urandom());
      send_request(MODE_SCHEDULE, 8'($urandom()), $urandom(), $urandom());
      send_request(MODE_CREATE, 8'($urandom()), $urandom(), $urandom());
      send_request(MODE_YIELD, 8'd0, $urandom(), $urandom());

      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("thread_slot_and_ready_queue_scheduler_tb: clean");
      else
         $display("thread_slot_and_ready_queue_scheduler_tb: errors");
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("thread_slot_and_ready_queue_scheduler_tb: errors");
      $finish;
   end

endmodule
